// File: design/cdt_pkg.sv
// shared types, codes and defaults of the countdown timer controller
package cdt_pkg;

  // default width of the set and elapsed time counters
  localparam int unsigned TIME_BITS_DEF = 16;

  // configuration register indexes
  localparam logic [1:0] CFG_STEP_SECONDS     = 2'd0;
  localparam logic [1:0] CFG_TICKS_PER_SECOND = 2'd1;
  localparam logic [1:0] CFG_STATS_HOLD_TICKS = 2'd2;
  localparam logic [1:0] CFG_BEEP_PHASE       = 2'd3;

  // configuration reset values
  localparam logic [7:0] STEP_SECONDS_RST     = 8'd60;
  localparam logic [7:0] TICKS_PER_SECOND_RST = 8'd10;
  localparam logic [7:0] STATS_HOLD_TICKS_RST = 8'd30;
  localparam logic [7:0] BEEP_PHASE_RST       = 8'd5;

  // mode codes
  localparam logic [2:0] MODE_IDLE  = 3'd0;
  localparam logic [2:0] MODE_SET   = 3'd1;
  localparam logic [2:0] MODE_COUNT = 3'd2;
  localparam logic [2:0] MODE_PAUSE = 3'd3;
  localparam logic [2:0] MODE_STATS = 3'd4;

  // event codes
  localparam logic [2:0] ACT_INC   = 3'd0;
  localparam logic [2:0] ACT_DEC   = 3'd1;
  localparam logic [2:0] ACT_TICK  = 3'd2;
  localparam logic [2:0] ACT_START = 3'd3;
  localparam logic [2:0] ACT_ABORT = 3'd4;

  // event outcome
  typedef enum logic [1:0] {
    ST_IGNORED = 2'd0,
    ST_HANDLED = 2'd1,
    ST_TRANS   = 2'd2
  } status_e;

  // message codes
  localparam logic [1:0] MSG_NONE       = 2'd0;
  localparam logic [1:0] MSG_SET_TIME   = 2'd1;
  localparam logic [1:0] MSG_PRODUCTIVE = 2'd2;
  localparam logic [1:0] MSG_PAUSED     = 2'd3;

  // register width
  localparam int unsigned CFG_DATA_BITS = 8;
  localparam int unsigned CFG_INDEX_BITS = 2;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] subsecond;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [1:0]  status;
    logic        clear_display;
    logic        show_time;
    logic [31:0] time_value;
    logic [1:0]  message;
    logic        beep;
  } out_item_t;

  typedef struct packed {
    logic [7:0] step_seconds;
    logic [7:0] ticks_per_second;
    logic [7:0] stats_hold_ticks;
    logic [7:0] beep_phase;
  } cfg_t;

endpackage

// File: design/cdt_fsm.sv
// mode state machine with timer state, exit and entry actions per item
module cdt_fsm #(
  parameter int unsigned TIME_BITS = cdt_pkg::TIME_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cdt_pkg::cfg_t     cfg_i,
  input  logic              item_en_i,
  input  cdt_pkg::in_item_t item_i,
  output cdt_pkg::out_item_t result_o
);
  import cdt_pkg::*;

  logic [2:0]           mode_q, mode_d;
  logic [TIME_BITS-1:0] set_q, set_d;
  logic [TIME_BITS-1:0] elapsed_q, elapsed_d;
  logic [31:0]          prod_q, prod_d;
  logic [7:0]           cprescale_q, cprescale_d;
  logic [7:0]           sprescale_q, sprescale_d;

  logic [TIME_BITS:0]   step_w;
  logic [TIME_BITS:0]   set_sum;
  logic                 inc_ok;
  logic                 dec_ok;
  logic [TIME_BITS-1:0] set_diff;
  logic [7:0]           cpre_inc;
  logic [7:0]           spre_inc;
  logic [32:0]          prod_sum;
  status_e              status;
  logic                 clr;
  logic                 show;
  logic [31:0]          tval;
  logic [1:0]           msg;
  logic                 beep;
  logic [TIME_BITS-1:0] set_tick;

  // shared arithmetic on the stored time
  assign step_w   = (TIME_BITS+1)'(cfg_i.step_seconds);
  assign set_sum  = {1'b0, set_q} + step_w;
  assign inc_ok   = ~set_sum[TIME_BITS];
  assign dec_ok   = ({1'b0, set_q} >= step_w);
  assign set_diff = set_q - step_w[TIME_BITS-1:0];
  assign cpre_inc = cprescale_q + 8'd1;
  assign spre_inc = sprescale_q + 8'd1;
  assign set_tick = (set_q == '0) ? '0 : set_q - 1'b1;

  // event handling, then exit and entry actions on a transition
  always_comb begin
    mode_d      = mode_q;
    set_d       = set_q;
    elapsed_d   = elapsed_q;
    prod_d      = prod_q;
    cprescale_d = cprescale_q;
    sprescale_d = sprescale_q;
    status      = ST_IGNORED;
    clr         = 1'b0;
    show        = 1'b0;
    tval        = '0;
    msg         = MSG_NONE;
    beep        = 1'b0;
    prod_sum    = '0;

    case (mode_q)
      MODE_SET: begin
        if (item_i.action == ACT_INC) begin
          if (inc_ok) begin
            set_d  = set_sum[TIME_BITS-1:0];
            show   = 1'b1;
            tval   = 32'(set_sum[TIME_BITS-1:0]);
            status = ST_HANDLED;
          end
        end else if (item_i.action == ACT_DEC) begin
          if (dec_ok) begin
            set_d  = set_diff;
            show   = 1'b1;
            tval   = 32'(set_diff);
            status = ST_HANDLED;
          end
        end else if (item_i.action == ACT_START) begin
          if (dec_ok) begin
            mode_d = MODE_COUNT;
            status = ST_TRANS;
          end
        end else if (item_i.action == ACT_ABORT) begin
          mode_d = MODE_IDLE;
          status = ST_TRANS;
        end
      end
      MODE_COUNT: begin
        if (item_i.action == ACT_TICK) begin
          if (cpre_inc == cfg_i.ticks_per_second) begin
            cprescale_d = '0;
            set_d       = set_tick;
            if (elapsed_q != '1) begin
              elapsed_d = elapsed_q + 1'b1;
            end
            show = 1'b1;
            tval = 32'(set_tick);
            if (set_tick == '0) begin
              mode_d = MODE_IDLE;
              status = ST_TRANS;
            end else begin
              status = ST_HANDLED;
            end
          end else begin
            cprescale_d = cpre_inc;
          end
        end else if (item_i.action == ACT_START) begin
          mode_d = MODE_PAUSE;
          status = ST_TRANS;
        end else if (item_i.action == ACT_ABORT) begin
          mode_d = MODE_IDLE;
          status = ST_TRANS;
        end
      end
      MODE_PAUSE: begin
        if (item_i.action == ACT_INC) begin
          if (inc_ok) begin
            set_d  = set_sum[TIME_BITS-1:0];
            mode_d = MODE_SET;
            status = ST_TRANS;
          end
        end else if (item_i.action == ACT_DEC) begin
          if (dec_ok) begin
            set_d  = set_diff;
            mode_d = MODE_SET;
            status = ST_TRANS;
          end
        end else if (item_i.action == ACT_START) begin
          mode_d = MODE_COUNT;
          status = ST_TRANS;
        end else if (item_i.action == ACT_ABORT) begin
          mode_d = MODE_IDLE;
          status = ST_TRANS;
        end
      end
      MODE_STATS: begin
        if (item_i.action == ACT_TICK) begin
          if (spre_inc == cfg_i.stats_hold_ticks) begin
            sprescale_d = '0;
            mode_d      = MODE_IDLE;
            status      = ST_TRANS;
          end else begin
            sprescale_d = spre_inc;
          end
        end
      end
      default: begin
        // idle, and any unused code behaves as idle
        if (item_i.action == ACT_INC) begin
          if (inc_ok) begin
            set_d  = set_sum[TIME_BITS-1:0];
            mode_d = MODE_SET;
            status = ST_TRANS;
          end
        end else if (item_i.action == ACT_TICK) begin
          if (item_i.subsecond == cfg_i.beep_phase) begin
            beep   = 1'b1;
            status = ST_HANDLED;
          end
        end else if (item_i.action == ACT_START) begin
          mode_d = MODE_STATS;
          status = ST_TRANS;
        end
      end
    endcase

    if (status == ST_TRANS) begin
      // exit action of the old mode
      if (mode_q == MODE_COUNT) begin
        prod_sum  = {1'b0, prod_q} + 33'(elapsed_d);
        prod_d    = prod_sum[32] ? '1 : prod_sum[31:0];
        elapsed_d = '0;
      end else begin
        clr  = 1'b1;
        show = 1'b0;
        tval = '0;
      end
      // entry action of the new mode
      case (mode_d)
        MODE_SET: begin
          show = 1'b1;
          tval = 32'(set_d);
        end
        MODE_PAUSE: begin
          msg = MSG_PAUSED;
        end
        MODE_STATS: begin
          show = 1'b1;
          tval = prod_d;
          msg  = MSG_PRODUCTIVE;
        end
        MODE_IDLE: begin
          set_d     = '0;
          elapsed_d = '0;
          show      = 1'b1;
          tval      = '0;
          msg       = MSG_SET_TIME;
        end
        default: begin
          msg = MSG_NONE;
        end
      endcase
    end
  end

  // result of the current item
  always_comb begin
    result_o.mode          = mode_d;
    result_o.status        = status;
    result_o.clear_display = clr;
    result_o.show_time     = show;
    result_o.time_value    = show ? tval : 32'd0;
    result_o.message       = msg;
    result_o.beep          = beep;
  end

  // timer state, updated once per item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_IDLE;
      set_q       <= '0;
      elapsed_q   <= '0;
      prod_q      <= '0;
      cprescale_q <= '0;
      sprescale_q <= '0;
    end else if (item_en_i) begin
      mode_q      <= mode_d;
      set_q       <= set_d;
      elapsed_q   <= elapsed_d;
      prod_q      <= prod_d;
      cprescale_q <= cprescale_d;
      sprescale_q <= sprescale_d;
    end
  end

endmodule

// File: design/countdown_timer_controller_top.sv
// top level of the countdown timer controller: config registers, item and result registers
// Countdown timer controller. Each input item is one event (increment, decrement, tick,
// start/pause, abort) and gives exactly one result item: the mode after the event, its
// outcome, display clear, time shown, message code and beep. One item is accepted every
// clock cycle unless the input stalls. An accepted item is held in the input register and
// its result is loaded into the result register when the item advances, which needs the
// result register empty or not stalled, and is then offered on the output. Stalling the output
// holds the result register, and the input stalls only when both registers are full.
// Configuration writes (step seconds, ticks per second, stats hold ticks, beep phase) are
// to be made while no item is in flight. TIME_BITS sets the width of the set and elapsed
// time.
module countdown_timer_controller_top #(
  parameter int unsigned TIME_BITS = cdt_pkg::TIME_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [cdt_pkg::CFG_INDEX_BITS-1:0]   cfg_index_i,
  input  logic [cdt_pkg::CFG_DATA_BITS-1:0]    cfg_wdata_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  cdt_pkg::in_item_t                    in_item_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output cdt_pkg::out_item_t                   out_item_o
);
  import cdt_pkg::*;

  cfg_t      cfg_q;
  logic      in_valid_q;
  in_item_t  in_item_q;
  logic      out_valid_q;
  out_item_t out_item_q;
  out_item_t result;
  logic      advance;
  logic      accept;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.step_seconds     <= STEP_SECONDS_RST;
      cfg_q.ticks_per_second <= TICKS_PER_SECOND_RST;
      cfg_q.stats_hold_ticks <= STATS_HOLD_TICKS_RST;
      cfg_q.beep_phase       <= BEEP_PHASE_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_STEP_SECONDS:     cfg_q.step_seconds     <= cfg_wdata_i;
        CFG_TICKS_PER_SECOND: cfg_q.ticks_per_second <= cfg_wdata_i;
        CFG_STATS_HOLD_TICKS: cfg_q.stats_hold_ticks <= cfg_wdata_i;
        CFG_BEEP_PHASE:       cfg_q.beep_phase       <= cfg_wdata_i;
        default:              cfg_q                  <= cfg_q;
      endcase
    end
  end

  // pipeline handshake
  assign advance    = in_valid_q & (~out_valid_q | ~out_stall_i);
  assign in_stall_o = in_valid_q & ~advance;
  assign accept     = in_valid_i & ~in_stall_o;

  // input item register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_item_q <= in_item_i;
    end
  end

  // state machine on the registered item
  cdt_fsm #(
    .TIME_BITS (TIME_BITS)
  ) u_fsm (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .item_en_i (advance),
    .item_i    (in_item_q),
    .result_o  (result)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (~out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_item_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule
